FILE: rtl/core/apa_pkg.sv
// shared types, constants and saturation helpers for the adaptive pid axis
package apa_pkg;

  localparam int DATA_W  = 32;
  localparam int CNT_W   = 8;
  localparam int REG_W   = 31;
  localparam int FRAC_W  = 16;
  localparam int WIDE_W  = 54;
  localparam int DIV_N   = 64;
  localparam int DCNT_W  = 6;

  localparam logic signed [DATA_W-1:0] RawLimit   = 32'sd983040;
  localparam logic signed [DATA_W-1:0] IntegClear = 32'sd196608;
  localparam logic [CNT_W-1:0] CrossHigh   = 8'd15;
  localparam logic [CNT_W-1:0] CrossLow    = 8'd3;
  localparam logic [CNT_W-1:0] StableLimit = 8'd10;
  localparam logic [CNT_W-1:0] CountTop    = 8'd255;
  localparam logic [DIV_N-1:0] DerivSat    = 64'h0004_0000_0000_0000;
  localparam logic [DCNT_W-1:0] DivLast    = 6'd63;

  localparam logic signed [WIDE_W-1:0] DmaxWide = 54'sd2147483647;
  localparam logic signed [WIDE_W-1:0] DminWide = -54'sd2147483648;

  typedef enum logic [2:0] {
    REG_BASE_KP   = 3'd0,
    REG_BASE_KI   = 3'd1,
    REG_KD_GAIN   = 3'd2,
    REG_MAX_SPEED = 3'd3,
    REG_MIN_SPEED = 3'd4,
    REG_KP_STEP   = 3'd5,
    REG_KI_STEP   = 3'd6
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADAPT_A,
    S_ADAPT_B,
    S_MUL_P,
    S_MUL_I,
    S_TERM,
    S_MUL_T,
    S_MUL_D,
    S_DIV_LOAD,
    S_DIV,
    S_SUM,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP,
    MUL_KI,
    MUL_TERM,
    MUL_KD
  } mul_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] raw_error;
    logic signed [DATA_W-1:0] control_error;
    logic [REG_W-1:0]         sample_period;
    logic                     block_positive;
    logic                     block_negative;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] speed_command;
    logic signed [DATA_W-1:0] gain_kp_now;
    logic signed [DATA_W-1:0] gain_ki_now;
    logic [CNT_W-1:0]         crossings_seen;
  } out_word_t;

  typedef struct packed {
    logic    latch;
    logic    adapt_a;
    logic    adapt_b;
    mul_op_t mul_op;
    logic    take_prop;
    logic    take_term;
    logic    take_integ;
    logic    div_load;
    logic    div_step;
    logic    take_sum;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } status_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > DmaxWide) begin
      r = DmaxWide[DATA_W-1:0];
    end else if (v < DminWide) begin
      r = DminWide[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c < CountTop) ? c + 8'd1 : CountTop;
    return r;
  endfunction

endpackage

FILE: rtl/core/apa_ctrl.sv
// sequencing state machine for one control tick
module apa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  apa_pkg::status_t status,
  output apa_pkg::cmd_t    cmd
);

  apa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      apa_pkg::S_IDLE:     if (in_valid) state_next = apa_pkg::S_ADAPT_A;
      apa_pkg::S_ADAPT_A:  state_next = apa_pkg::S_ADAPT_B;
      apa_pkg::S_ADAPT_B:  state_next = apa_pkg::S_MUL_P;
      apa_pkg::S_MUL_P:    state_next = apa_pkg::S_MUL_I;
      apa_pkg::S_MUL_I:    state_next = apa_pkg::S_TERM;
      apa_pkg::S_TERM:     state_next = apa_pkg::S_MUL_T;
      apa_pkg::S_MUL_T:    state_next = apa_pkg::S_MUL_D;
      apa_pkg::S_MUL_D:    state_next = apa_pkg::S_DIV_LOAD;
      apa_pkg::S_DIV_LOAD: state_next = apa_pkg::S_DIV;
      apa_pkg::S_DIV:      if (status.div_last) state_next = apa_pkg::S_SUM;
      apa_pkg::S_SUM:      state_next = apa_pkg::S_DONE;
      apa_pkg::S_DONE:     if (!status.out_busy) state_next = apa_pkg::S_IDLE;
      default:             state_next = apa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_op = apa_pkg::MUL_NONE;
    in_stall = (state != apa_pkg::S_IDLE);
    unique case (state)
      apa_pkg::S_IDLE:     cmd.latch = in_valid;
      apa_pkg::S_ADAPT_A:  cmd.adapt_a = 1'b1;
      apa_pkg::S_ADAPT_B:  cmd.adapt_b = 1'b1;
      apa_pkg::S_MUL_P:    cmd.mul_op = apa_pkg::MUL_KP;
      apa_pkg::S_MUL_I: begin
        cmd.take_prop = 1'b1;
        cmd.mul_op = apa_pkg::MUL_KI;
      end
      apa_pkg::S_TERM:     cmd.take_term = 1'b1;
      apa_pkg::S_MUL_T:    cmd.mul_op = apa_pkg::MUL_TERM;
      apa_pkg::S_MUL_D: begin
        cmd.take_integ = 1'b1;
        cmd.mul_op = apa_pkg::MUL_KD;
      end
      apa_pkg::S_DIV_LOAD: cmd.div_load = 1'b1;
      apa_pkg::S_DIV:      cmd.div_step = 1'b1;
      apa_pkg::S_SUM:      cmd.take_sum = 1'b1;
      apa_pkg::S_DONE:     cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/apa_datapath.sv
// gain adaptation, shared multiplier, serial divider and output stage
module apa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [apa_pkg::REG_W-1:0]     cfg_data,
  input  apa_pkg::in_word_t             in_word,
  input  apa_pkg::cmd_t                 cmd,
  output apa_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output apa_pkg::out_word_t            out_word
);

  logic [apa_pkg::REG_W-1:0] base_kp, base_ki, kd_gain, max_speed, min_speed, kp_step, ki_step;
  logic signed [apa_pkg::DATA_W-1:0] kp, ki, integral_sum, previous_error;
  logic [apa_pkg::CNT_W-1:0] cross_cnt, stable_cnt;

  apa_pkg::in_word_t word;
  logic signed [63:0] prod;
  logic signed [47:0] prop;
  logic signed [apa_pkg::DATA_W-1:0] term, integ;
  logic [apa_pkg::DIV_N-1:0] dq;
  logic [apa_pkg::REG_W:0] rem;
  logic [apa_pkg::DCNT_W-1:0] dcnt;
  logic dneg;
  logic signed [apa_pkg::WIDE_W-1:0] sum;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      base_kp <= '0;
      base_ki <= '0;
      kd_gain <= '0;
      max_speed <= '0;
      min_speed <= '0;
      kp_step <= '0;
      ki_step <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        apa_pkg::REG_BASE_KP:   base_kp <= cfg_data;
        apa_pkg::REG_BASE_KI:   base_ki <= cfg_data;
        apa_pkg::REG_KD_GAIN:   kd_gain <= cfg_data;
        apa_pkg::REG_MAX_SPEED: max_speed <= cfg_data;
        apa_pkg::REG_MIN_SPEED: min_speed <= cfg_data;
        apa_pkg::REG_KP_STEP:   kp_step <= cfg_data;
        apa_pkg::REG_KI_STEP:   ki_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // adaptation
  logic signed [apa_pkg::WIDE_W-1:0] kis_w, kp2_w, kp4_w;
  logic raw_big, crossed;
  logic signed [apa_pkg::DATA_W-1:0] ki_a, ki_dec, kp_dec;
  logic [apa_pkg::CNT_W-1:0] cross_a, stable_a;

  assign kis_w = $signed({23'b0, ki_step});
  assign kp2_w = $signed({22'b0, kp_step, 1'b0});
  assign kp4_w = $signed({21'b0, kp_step, 2'b00});
  assign raw_big = (word.raw_error > apa_pkg::RawLimit) ||
                   (word.raw_error < -apa_pkg::RawLimit);
  assign crossed = (previous_error > 0 && word.raw_error < 0) ||
                   (previous_error < 0 && word.raw_error > 0);

  always_comb begin
    if (raw_big) begin
      ki_a = apa_pkg::sat_data(54'(ki) + kis_w);
    end else if (ki > 0) begin
      ki_a = apa_pkg::sat_data(54'(ki) - kis_w);
    end else begin
      ki_a = ki;
    end
    cross_a = crossed ? apa_pkg::count_up(cross_cnt) : cross_cnt;
    stable_a = crossed ? '0 : apa_pkg::count_up(stable_cnt);
    ki_dec = (ki > 0) ? apa_pkg::sat_data(54'(ki) - kis_w) : ki;
    if (cross_cnt > apa_pkg::CrossHigh) begin
      kp_dec = (kp > 0) ? apa_pkg::sat_data(54'(kp) - kp4_w) : kp;
    end else begin
      kp_dec = (kp > 0) ? apa_pkg::sat_data(54'(kp) - kp2_w) : kp;
    end
  end

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_full;

  always_comb begin
    unique case (cmd.mul_op)
      apa_pkg::MUL_KP: begin
        mul_a = 34'(kp);
        mul_b = 34'(word.control_error);
      end
      apa_pkg::MUL_KI: begin
        mul_a = 34'(ki);
        mul_b = 34'(word.control_error);
      end
      apa_pkg::MUL_TERM: begin
        mul_a = 34'(term);
        mul_b = $signed({3'b0, word.sample_period});
      end
      apa_pkg::MUL_KD: begin
        mul_a = $signed({3'b0, kd_gain});
        mul_b = 34'(word.control_error) - 34'(previous_error);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // divider step
  logic [apa_pkg::REG_W:0] rem_sh;
  logic div_ge;
  assign rem_sh = {rem[apa_pkg::REG_W-1:0], dq[apa_pkg::DIV_N-1]};
  assign div_ge = rem_sh >= {1'b0, word.sample_period};

  // derivative and integral base
  logic [50:0] dmag;
  logic signed [51:0] deriv;
  logic signed [apa_pkg::DATA_W-1:0] integ_base;
  assign dmag = (dq > apa_pkg::DerivSat) ? apa_pkg::DerivSat[50:0] : dq[50:0];
  assign deriv = (word.sample_period == '0) ? '0 :
                 dneg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  assign integ_base = (word.control_error < apa_pkg::IntegClear) ? '0 : integral_sum;

  // output stage
  logic signed [apa_pkg::WIDE_W-1:0] vmax, vmin, clamp, speed;
  assign vmax = $signed({23'b0, max_speed});
  assign vmin = $signed({23'b0, min_speed});

  always_comb begin
    if (sum > vmax) begin
      clamp = vmax;
    end else if (sum < -vmax) begin
      clamp = -vmax;
    end else begin
      clamp = sum;
    end
    speed = clamp;
    if ((clamp > -vmin && clamp < 0) || (clamp > 0 && clamp < vmin)) speed = '0;
    if (word.block_positive && speed > 0) speed = '0;
    if (word.block_negative && speed < 0) speed = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0;
      ki <= '0;
      integral_sum <= '0;
      previous_error <= '0;
      cross_cnt <= '0;
      stable_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == apa_pkg::REG_BASE_KP) kp <= $signed({1'b0, cfg_data});
      if (cfg_write && cfg_index == apa_pkg::REG_BASE_KI) ki <= $signed({1'b0, cfg_data});
      if (cmd.adapt_a) begin
        ki <= ki_a;
        cross_cnt <= cross_a;
        stable_cnt <= stable_a;
      end
      if (cmd.adapt_b) begin
        if (cross_cnt > apa_pkg::CrossLow) begin
          ki <= ki_dec;
        end
        if (stable_cnt > apa_pkg::StableLimit) begin
          cross_cnt <= '0;
          kp <= $signed({1'b0, base_kp});
        end else if (cross_cnt > apa_pkg::CrossLow) begin
          kp <= kp_dec;
        end
      end
      if (cmd.finish) begin
        previous_error <= word.control_error;
        integral_sum <= integ;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) word <= in_word;
    if (cmd.mul_op != apa_pkg::MUL_NONE) prod <= mul_full[63:0];
    if (cmd.take_prop) prop <= $signed(prod[63:16]);
    if (cmd.take_term) term <= apa_pkg::sat_data(54'($signed(prod[63:16])));
    if (cmd.take_integ) begin
      integ <= apa_pkg::sat_data(54'(integ_base) + 54'($signed(prod[63:16])));
    end
    if (cmd.div_load) begin
      dneg <= prod[63];
      dq <= prod[63] ? 64'(-prod) : 64'(prod);
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem <= div_ge ? rem_sh - {1'b0, word.sample_period} : rem_sh;
      dq <= {dq[apa_pkg::DIV_N-2:0], div_ge};
      dcnt <= dcnt + 6'd1;
    end
    if (cmd.take_sum) sum <= 54'(prop) + 54'(integ) + 54'(deriv);
    if (cmd.finish) begin
      out_word.speed_command <= speed[apa_pkg::DATA_W-1:0];
      out_word.gain_kp_now <= kp;
      out_word.gain_ki_now <= ki;
      out_word.crossings_seen <= cross_cnt;
    end
  end

  assign status.div_last = (dcnt == apa_pkg::DivLast);
  assign status.out_busy = out_valid && out_stall;

endmodule

FILE: rtl/core/adaptive_pid_axis.sv
// top level of the adaptive pid axis controller
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    apa_pkg::in_word_t
//  out      out  out_valid/out_stall  apa_pkg::out_word_t
//  cfg      in   cfg_write            cfg_index, cfg_data
//
// one word at a time, no new word until the last is done: idle accept, two adapt
// steps, four shared multiplies with one saturate step, a divider load, a 64-step
// restoring divider for the derivative term, a sum step and the done step
// in_stall is high from the accept until the result enters the output register
// a result held by out_stall waits in the output register; the next word is
// taken meanwhile and its result waits in the done state
// rst is synchronous and clears gains, counters, history and config
module adaptive_pid_axis (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [apa_pkg::REG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  apa_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output apa_pkg::out_word_t        out_word
);

  apa_pkg::cmd_t    cmd;
  apa_pkg::status_t status;

  apa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  apa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/core/apa_checker.sv
// port-level checks for the adaptive pid axis
module apa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input apa_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("out word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_word)) else $error("out word changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("accept while busy");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.speed_command != 32'sh8000_0000) else $error("clamp broken");

endmodule

bind adaptive_pid_axis apa_checker u_apa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
